FILE: rtl/core/rtc_counter_alarm_registers_unit_assert.svh
// assertion helpers for the rtc unit, clocked on clk_i and gated by rst_ni
`ifndef RTC_COUNTER_ALARM_REGISTERS_UNIT_ASSERT_SVH
`define RTC_COUNTER_ALARM_REGISTERS_UNIT_ASSERT_SVH

// same-cycle implication
`define RCAR_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rtc unit check failed");

// next-cycle implication
`define RCAR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rtc unit check failed");

`endif

FILE: rtl/core/rcar_pkg.sv
package rcar_pkg;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } mode_e;

  localparam int unsigned OffW = 7;

  localparam logic [OffW-1:0] OFF_SECONDS    = 7'h00;
  localparam logic [OffW-1:0] OFF_MINUTES    = 7'h04;
  localparam logic [OffW-1:0] OFF_HOURS      = 7'h08;
  localparam logic [OffW-1:0] OFF_DAYS       = 7'h0c;
  localparam logic [OffW-1:0] OFF_ALARM_SEC  = 7'h10;
  localparam logic [OffW-1:0] OFF_ALARM_MIN  = 7'h14;
  localparam logic [OffW-1:0] OFF_ALARM_HOUR = 7'h18;
  localparam logic [OffW-1:0] OFF_RECORD     = 7'h1c;
  localparam logic [OffW-1:0] OFF_CONTROL    = 7'h20;
  localparam logic [OffW-1:0] OFF_LOAD_SEC   = 7'h24;
  localparam logic [OffW-1:0] OFF_LOAD_MIN   = 7'h28;
  localparam logic [OffW-1:0] OFF_LOAD_HOUR  = 7'h2c;
  localparam logic [OffW-1:0] OFF_LOAD_DAYS  = 7'h30;
  localparam logic [OffW-1:0] OFF_STATUS     = 7'h34;

  // control register bits
  localparam int unsigned CTRL_ENABLE   = 0;
  localparam int unsigned CTRL_SEC_EN   = 1;
  localparam int unsigned CTRL_DAY_EN   = 4;
  localparam int unsigned CTRL_ALARM_EN = 5;
  localparam int unsigned CTRL_LOAD     = 6;

  // status register bits
  localparam int unsigned ST_SEC   = 0;
  localparam int unsigned ST_MIN   = 1;
  localparam int unsigned ST_HOUR  = 2;
  localparam int unsigned ST_DAY   = 3;
  localparam int unsigned ST_ALARM = 4;

  localparam logic [5:0] SEC_LAST  = 6'd59;
  localparam logic [5:0] MIN_LAST  = 6'd59;
  localparam logic [4:0] HOUR_LAST = 5'd23;

endpackage

FILE: rtl/core/rtc_counter_alarm_registers_unit.sv
// channel | valid      | ready      | payload
// in      | in_valid_i | in_ready_o | mode_i, reg_offset_i, write_data_i
// out     | out_valid_o| out_ready_i| read_data_o, alarm_flag_o, roll_flag_o
//
// one beat in, one beat out; a beat can enter every cycle while the output is not stalled
// path: input register, then the register update and result register
// reset clears all counters, alarm, load, control and status registers to zero
// a stalled output holds its beat while one more input beat waits in the input register
module rtc_counter_alarm_registers_unit import rcar_pkg::*; #(
  parameter int unsigned DAY_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          mode_i,
  input  logic [OffW-1:0]     reg_offset_i,
  input  logic [31:0]         write_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         read_data_o,
  output logic                alarm_flag_o,
  output logic                roll_flag_o
);

  // input stage
  logic            s1_valid_q;
  mode_e           s1_mode_q;
  logic [OffW-1:0] s1_off_q;
  logic [31:0]     s1_data_q;

  logic out_free;
  logic s1_fire;

  assign out_free   = !out_valid_o || out_ready_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_mode_q <= mode_e'(mode_i);
      s1_off_q  <= reg_offset_i;
      s1_data_q <= write_data_i;
    end
  end

  // architectural registers
  logic [5:0]          sec_q, sec_d;
  logic [5:0]          min_q, min_d;
  logic [4:0]          hour_q, hour_d;
  logic [DAY_BITS-1:0] days_q, days_d;
  logic [5:0]          al_sec_q, al_sec_d;
  logic [5:0]          al_min_q, al_min_d;
  logic [4:0]          al_hour_q, al_hour_d;
  logic [31:0]         record_q, record_d;
  logic [7:0]          ctrl_q, ctrl_d;
  logic [5:0]          ld_sec_q, ld_sec_d;
  logic [5:0]          ld_min_q, ld_min_d;
  logic [4:0]          ld_hour_q, ld_hour_d;
  logic [DAY_BITS-1:0] ld_days_q, ld_days_d;
  logic [4:0]          irq_q, irq_d;
  logic [31:0]         rdata;
  logic [3:0]          roll;

  always_comb begin
    sec_d     = sec_q;
    min_d     = min_q;
    hour_d    = hour_q;
    days_d    = days_q;
    al_sec_d  = al_sec_q;
    al_min_d  = al_min_q;
    al_hour_d = al_hour_q;
    record_d  = record_q;
    ctrl_d    = ctrl_q;
    ld_sec_d  = ld_sec_q;
    ld_min_d  = ld_min_q;
    ld_hour_d = ld_hour_q;
    ld_days_d = ld_days_q;
    irq_d     = irq_q;
    rdata     = '0;
    roll      = '0;

    case (s1_mode_q)
      MODE_TICK: begin
        if (ctrl_q[CTRL_ENABLE]) begin
          if (ctrl_q[CTRL_LOAD]) begin
            sec_d  = ld_sec_q;
            min_d  = ld_min_q;
            hour_d = ld_hour_q;
            days_d = ld_days_q;
            ctrl_d[CTRL_LOAD] = 1'b0;
          end else begin
            roll[ST_SEC] = 1'b1;
            // counters loaded past their limit wrap like the last value
            if (sec_q >= SEC_LAST) begin
              sec_d = '0;
              roll[ST_MIN] = 1'b1;
              if (min_q >= MIN_LAST) begin
                min_d = '0;
                roll[ST_HOUR] = 1'b1;
                if (hour_q >= HOUR_LAST) begin
                  hour_d = '0;
                  roll[ST_DAY] = 1'b1;
                  days_d = days_q + DAY_BITS'(1);
                end else begin
                  hour_d = hour_q + 5'd1;
                end
              end else begin
                min_d = min_q + 6'd1;
              end
            end else begin
              sec_d = sec_q + 6'd1;
            end
            irq_d[ST_DAY:ST_SEC] = irq_q[ST_DAY:ST_SEC] | (roll & ctrl_q[CTRL_DAY_EN:CTRL_SEC_EN]);
          end
          if (ctrl_q[CTRL_ALARM_EN] && sec_d == al_sec_q && min_d == al_min_q &&
              hour_d == al_hour_q) begin
            irq_d[ST_ALARM] = 1'b1;
          end
        end
      end
      MODE_READ: begin
        case (s1_off_q)
          OFF_SECONDS:    rdata = 32'(sec_q);
          OFF_MINUTES:    rdata = 32'(min_q);
          OFF_HOURS:      rdata = 32'(hour_q);
          OFF_DAYS:       rdata = 32'(days_q);
          OFF_ALARM_SEC:  rdata = 32'(al_sec_q);
          OFF_ALARM_MIN:  rdata = 32'(al_min_q);
          OFF_ALARM_HOUR: rdata = 32'(al_hour_q);
          OFF_RECORD:     rdata = record_q;
          OFF_CONTROL:    rdata = 32'(ctrl_q);
          OFF_LOAD_SEC:   rdata = 32'(ld_sec_q);
          OFF_LOAD_MIN:   rdata = 32'(ld_min_q);
          OFF_LOAD_HOUR:  rdata = 32'(ld_hour_q);
          OFF_LOAD_DAYS:  rdata = 32'(ld_days_q);
          OFF_STATUS:     rdata = 32'(irq_q);
          default:        rdata = '0;
        endcase
      end
      MODE_WRITE: begin
        case (s1_off_q)
          OFF_ALARM_SEC:  al_sec_d  = s1_data_q[5:0];
          OFF_ALARM_MIN:  al_min_d  = s1_data_q[5:0];
          OFF_ALARM_HOUR: al_hour_d = s1_data_q[4:0];
          OFF_RECORD:     record_d  = s1_data_q;
          OFF_CONTROL:    ctrl_d    = s1_data_q[7:0];
          OFF_LOAD_SEC:   ld_sec_d  = s1_data_q[5:0];
          OFF_LOAD_MIN:   ld_min_d  = s1_data_q[5:0];
          OFF_LOAD_HOUR:  ld_hour_d = s1_data_q[4:0];
          OFF_LOAD_DAYS:  ld_days_d = s1_data_q[DAY_BITS-1:0];
          // write one to clear
          OFF_STATUS:     irq_d     = irq_q & ~s1_data_q[4:0];
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q     <= '0;
      min_q     <= '0;
      hour_q    <= '0;
      days_q    <= '0;
      al_sec_q  <= '0;
      al_min_q  <= '0;
      al_hour_q <= '0;
      record_q  <= '0;
      ctrl_q    <= '0;
      ld_sec_q  <= '0;
      ld_min_q  <= '0;
      ld_hour_q <= '0;
      ld_days_q <= '0;
      irq_q     <= '0;
    end else if (s1_fire) begin
      sec_q     <= sec_d;
      min_q     <= min_d;
      hour_q    <= hour_d;
      days_q    <= days_d;
      al_sec_q  <= al_sec_d;
      al_min_q  <= al_min_d;
      al_hour_q <= al_hour_d;
      record_q  <= record_d;
      ctrl_q    <= ctrl_d;
      ld_sec_q  <= ld_sec_d;
      ld_min_q  <= ld_min_d;
      ld_hour_q <= ld_hour_d;
      ld_days_q <= ld_days_d;
      irq_q     <= irq_d;
    end
  end

  // result register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      read_data_o  <= rdata;
      alarm_flag_o <= irq_d[ST_ALARM];
      roll_flag_o  <= |irq_d[ST_DAY:ST_SEC];
    end
  end

  assign out_valid_o = out_valid_q;

`include "rtc_counter_alarm_registers_unit_assert.svh"

  // status cannot move while a result waits, so the shown levels track it
  `RCAR_ASSERT_IMPL(a_alarm_level, out_valid_o, alarm_flag_o == irq_q[ST_ALARM])
  `RCAR_ASSERT_IMPL(a_periodic_level, out_valid_o, roll_flag_o == |irq_q[ST_DAY:ST_SEC])
  `RCAR_ASSERT_IMPL(a_ready_only_on_stall, !in_ready_o,
                    s1_valid_q && out_valid_o && !out_ready_i)
  `RCAR_ASSERT_NEXT(a_seconds_tick_only, !(s1_fire && s1_mode_q == MODE_TICK), $stable(sec_q))
  `RCAR_ASSERT_NEXT(a_load_clears,
                    s1_fire && s1_mode_q == MODE_TICK && ctrl_q[CTRL_ENABLE],
                    !ctrl_q[CTRL_LOAD])

endmodule

FILE: test/rtc_counter_alarm_registers_unit_tb.sv
`timescale 1ns / 100ps

module rtc_counter_alarm_registers_unit_tb;
  import rcar_pkg::*;

  localparam int unsigned DAY_BITS = 16;

  // control bits that the package leaves unnamed
  localparam int unsigned CTRL_MIN_EN  = 2;
  localparam int unsigned CTRL_HOUR_EN = 3;
  localparam int unsigned CTRL_REFRESH = 7;

  localparam logic [OffW-1:0] OFF_UNALIGNED = 7'h12;
  localparam logic [OffW-1:0] OFF_UNMAPPED  = 7'h7c;

  typedef struct packed {
    logic [31:0] read_data;
    logic        alarm_flag;
    logic        roll_flag;
  } rtc_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [1:0]        mode_i = MODE_TICK;
  logic [OffW-1:0]   reg_offset_i = '0;
  logic [31:0]       write_data_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [31:0]       read_data_o;
  logic              alarm_flag_o;
  logic              roll_flag_o;

  // shadow copy of the clock registers
  logic [5:0]          cnt_sec = '0, cnt_min = '0;
  logic [4:0]          cnt_hour = '0;
  logic [DAY_BITS-1:0] cnt_day = '0;
  logic [5:0]          alm_sec = '0, alm_min = '0;
  logic [4:0]          alm_hour = '0;
  logic [31:0]         rec_word = '0;
  logic [7:0]          ctrl_reg = '0;
  logic [5:0]          ld_sec = '0, ld_min = '0;
  logic [4:0]          ld_hour = '0;
  logic [DAY_BITS-1:0] ld_day = '0;
  logic [4:0]          status_reg = '0;

  rtc_result_t rtc_result_q[$];
  rtc_result_t want_res;
  int          err_cnt = 0;
  bit          gaps_on = 1'b1;
  int          rx_hold_left = 0;

  logic [OffW-1:0] reg_map [14] = '{OFF_SECONDS, OFF_MINUTES, OFF_HOURS, OFF_DAYS,
                                    OFF_ALARM_SEC, OFF_ALARM_MIN, OFF_ALARM_HOUR,
                                    OFF_RECORD, OFF_CONTROL, OFF_LOAD_SEC, OFF_LOAD_MIN,
                                    OFF_LOAD_HOUR, OFF_LOAD_DAYS, OFF_STATUS};

  rtc_counter_alarm_registers_unit #(
    .DAY_BITS(DAY_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .reg_offset_i  (reg_offset_i),
    .write_data_i  (write_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .read_data_o   (read_data_o),
    .alarm_flag_o  (alarm_flag_o),
    .roll_flag_o   (roll_flag_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void clock_tick();
    logic [4:0] rolled;
    rolled = '0;
    if (!ctrl_reg[CTRL_ENABLE]) return;
    if (ctrl_reg[CTRL_LOAD]) begin
      cnt_sec  = ld_sec;
      cnt_min  = ld_min;
      cnt_hour = ld_hour;
      cnt_day  = ld_day;
      ctrl_reg[CTRL_LOAD] = 1'b0;
    end else begin
      rolled[ST_SEC] = 1'b1;
      // counters loaded past their limit wrap like the last value
      if (cnt_sec >= SEC_LAST) begin
        cnt_sec = '0;
        rolled[ST_MIN] = 1'b1;
        if (cnt_min >= MIN_LAST) begin
          cnt_min = '0;
          rolled[ST_HOUR] = 1'b1;
          if (cnt_hour >= HOUR_LAST) begin
            cnt_hour = '0;
            rolled[ST_DAY] = 1'b1;
            cnt_day++;
          end else begin
            cnt_hour++;
          end
        end else begin
          cnt_min++;
        end
      end else begin
        cnt_sec++;
      end
      status_reg[ST_DAY:ST_SEC] |= rolled[ST_DAY:ST_SEC] & ctrl_reg[CTRL_DAY_EN:CTRL_SEC_EN];
    end
    if (ctrl_reg[CTRL_ALARM_EN] && cnt_sec == alm_sec && cnt_min == alm_min &&
        cnt_hour == alm_hour)
      status_reg[ST_ALARM] = 1'b1;
  endfunction

  function automatic logic [31:0] reg_read(logic [OffW-1:0] off);
    case (off)
      OFF_SECONDS:    return 32'(cnt_sec);
      OFF_MINUTES:    return 32'(cnt_min);
      OFF_HOURS:      return 32'(cnt_hour);
      OFF_DAYS:       return 32'(cnt_day);
      OFF_ALARM_SEC:  return 32'(alm_sec);
      OFF_ALARM_MIN:  return 32'(alm_min);
      OFF_ALARM_HOUR: return 32'(alm_hour);
      OFF_RECORD:     return rec_word;
      OFF_CONTROL:    return 32'(ctrl_reg);
      OFF_LOAD_SEC:   return 32'(ld_sec);
      OFF_LOAD_MIN:   return 32'(ld_min);
      OFF_LOAD_HOUR:  return 32'(ld_hour);
      OFF_LOAD_DAYS:  return 32'(ld_day);
      OFF_STATUS:     return 32'(status_reg);
      default:        return '0;
    endcase
  endfunction

  function automatic void reg_write(logic [OffW-1:0] off, logic [31:0] data);
    case (off)
      OFF_ALARM_SEC:  alm_sec = data[5:0];
      OFF_ALARM_MIN:  alm_min = data[5:0];
      OFF_ALARM_HOUR: alm_hour = data[4:0];
      OFF_RECORD:     rec_word = data;
      OFF_CONTROL:    ctrl_reg = data[7:0];
      OFF_LOAD_SEC:   ld_sec = data[5:0];
      OFF_LOAD_MIN:   ld_min = data[5:0];
      OFF_LOAD_HOUR:  ld_hour = data[4:0];
      OFF_LOAD_DAYS:  ld_day = data[DAY_BITS-1:0];
      OFF_STATUS:     status_reg &= ~data[4:0];
      default: ;
    endcase
  endfunction

  function automatic rtc_result_t rtc_model_step(mode_e mode, logic [OffW-1:0] off,
                                                 logic [31:0] data);
    rtc_result_t res;
    res.read_data = '0;
    case (mode)
      MODE_TICK:  clock_tick();
      MODE_READ:  res.read_data = reg_read(off);
      MODE_WRITE: reg_write(off, data);
      default: ;
    endcase
    res.alarm_flag = status_reg[ST_ALARM];
    res.roll_flag  = |status_reg[ST_DAY:ST_SEC];
    return res;
  endfunction

  // result check first, then predict the beat taken at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (rtc_result_q.size() == 0) begin
          $error("result beat with no expectation waiting");
          err_cnt++;
        end else begin
          want_res = rtc_result_q.pop_front();
          if (read_data_o !== want_res.read_data) begin
            $error("read_data: expected %h, got %h", want_res.read_data, read_data_o);
            err_cnt++;
          end
          if (alarm_flag_o !== want_res.alarm_flag) begin
            $error("alarm_flag: expected %b, got %b", want_res.alarm_flag, alarm_flag_o);
            err_cnt++;
          end
          if (roll_flag_o !== want_res.roll_flag) begin
            $error("roll_flag: expected %b, got %b", want_res.roll_flag, roll_flag_o);
            err_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_o)
        rtc_result_q.push_back(rtc_model_step(mode_e'(mode_i), reg_offset_i, write_data_i));
    end
  end

  // receiver side: random stalls, a counted hold-off, or always ready with gaps off
  always @(posedge clk_i) begin
    if (rx_hold_left > 0) begin
      out_ready_i <= 1'b0;
      rx_hold_left = rx_hold_left - 1;
    end else if (gaps_on) begin
      out_ready_i <= ($urandom_range(0, 99) >= 33);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_beat(mode_e mode, logic [OffW-1:0] off, logic [31:0] data);
    while (gaps_on && $urandom_range(0, 99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    reg_offset_i <= off;
    write_data_i <= data;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_random_beat();
    mode_e           mode;
    logic [OffW-1:0] off;
    logic [31:0]     data;
    int unsigned     pick;
    pick = $urandom_range(0, 99);
    mode = (pick < 45) ? MODE_TICK : (pick < 75) ? MODE_READ : MODE_WRITE;
    off  = ($urandom_range(0, 9) == 0) ? OffW'($urandom_range(0, 127))
                                       : reg_map[$urandom_range(0, 13)];
    data = $urandom();
    if (mode == MODE_WRITE) begin
      // bias toward a running clock near its rollover points
      case (off)
        OFF_CONTROL: data[CTRL_ENABLE] = ($urandom_range(0, 9) != 0);
        OFF_LOAD_SEC, OFF_LOAD_MIN, OFF_ALARM_SEC, OFF_ALARM_MIN:
          if ($urandom_range(0, 1)) data[5:0] = 6'($urandom_range(55, 63));
        OFF_LOAD_HOUR, OFF_ALARM_HOUR:
          if ($urandom_range(0, 1)) data[4:0] = 5'($urandom_range(20, 31));
        default: ;
      endcase
    end
    send_beat(mode, off, data);
  endtask

  task automatic test_register_access();
    send_beat(MODE_WRITE, OFF_RECORD, '1);
    send_beat(MODE_WRITE, OFF_LOAD_DAYS, '1);
    // every control bit but enable and refresh, so the load stays pending
    send_beat(MODE_WRITE, OFF_CONTROL, 32'hffff_ff7e);
    send_beat(MODE_WRITE, OFF_SECONDS, '1);
    send_beat(MODE_WRITE, OffW'(OFF_ALARM_SEC + 3), '1);
    send_beat(MODE_READ, OFF_RECORD, '0);
    send_beat(MODE_READ, OFF_LOAD_DAYS, '0);
    send_beat(MODE_READ, OFF_CONTROL, '0);
    send_beat(MODE_READ, OFF_SECONDS, '0);
    send_beat(MODE_READ, OFF_UNALIGNED, '1);
    send_beat(MODE_READ, OFF_UNMAPPED, '0);
  endtask

  task automatic test_load_and_rollover();
    logic [7:0] ctrl_all;
    ctrl_all = '0;
    ctrl_all[CTRL_ENABLE]   = 1'b1;
    ctrl_all[CTRL_SEC_EN]   = 1'b1;
    ctrl_all[CTRL_MIN_EN]   = 1'b1;
    ctrl_all[CTRL_HOUR_EN]  = 1'b1;
    ctrl_all[CTRL_DAY_EN]   = 1'b1;
    ctrl_all[CTRL_ALARM_EN] = 1'b1;
    ctrl_all[CTRL_LOAD]     = 1'b1;
    ctrl_all[CTRL_REFRESH]  = 1'b1;
    send_beat(MODE_TICK, '0, '0);
    send_beat(MODE_WRITE, OFF_LOAD_SEC, 32'd63);
    send_beat(MODE_WRITE, OFF_LOAD_MIN, 32'd59);
    send_beat(MODE_WRITE, OFF_LOAD_HOUR, 32'd23);
    send_beat(MODE_WRITE, OFF_CONTROL, 32'(ctrl_all));
    // load, then a full rollover into the alarm time of zero
    send_beat(MODE_TICK, '0, '0);
    send_beat(MODE_TICK, '0, '1);
    send_beat(MODE_READ, OFF_CONTROL, '0);
    send_beat(MODE_READ, OFF_DAYS, '0);
    send_beat(MODE_READ, OFF_STATUS, '0);
    send_beat(MODE_WRITE, OFF_STATUS, '1);
    send_beat(MODE_READ, OFF_STATUS, '0);
  endtask

  task automatic test_output_backpressure();
    rx_hold_left = 80;
    repeat (30) send_random_beat();
  endtask

  task automatic test_random_traffic();
    repeat (400) send_random_beat();
    gaps_on = 1'b0;
    repeat (400) send_random_beat();
    gaps_on = 1'b1;
    repeat (400) send_random_beat();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_access();
    test_load_and_rollover();
    test_output_backpressure();
    test_random_traffic();
    in_valid_i <= 1'b0;
    while (rtc_result_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
